/* design/srmi_pkg.sv */
// Shared types, constants and helpers for the sorted range map insert core.
`timescale 1ns / 1ps

package srmi_pkg;

  // Field widths and fixed address geometry
  localparam int ADDR_W        = 48;
  localparam int PAGE_SHIFT    = 12;
  localparam int PAGES_W       = 36;
  localparam int TYPE_W        = 4;
  localparam int RIDX_W        = 5;
  localparam int STATUS_W      = 3;
  localparam int COUNT_OUT_W   = 6;
  localparam int MAX_RANGES_DEF = 32;

  localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}};
  localparam logic [ADDR_W-1:0] PAGE_LIM  = ADDR_MASK >> PAGE_SHIFT;

  // Operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PREPEND  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_APPEND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INSERT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd6;
  localparam logic [STATUS_W-1:0] ST_READ_BAD = 3'd7;

  // Usable firmware memory types
  localparam logic [TYPE_W-1:0] MT_LOADER_CODE = 4'd1;
  localparam logic [TYPE_W-1:0] MT_LOADER_DATA = 4'd2;
  localparam logic [TYPE_W-1:0] MT_BOOT_CODE   = 4'd3;
  localparam logic [TYPE_W-1:0] MT_BOOT_DATA   = 4'd4;
  localparam logic [TYPE_W-1:0] MT_CONVENTIONAL = 4'd7;

  typedef struct packed {
    logic                operation;
    logic [TYPE_W-1:0]   mem_type;
    logic [ADDR_W-1:0]   phys_base;
    logic [PAGES_W-1:0]  page_count;
    logic [RIDX_W-1:0]   read_index;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] range_count;
    logic [ADDR_W-1:0]      range_start_out;
    logic [ADDR_W-1:0]      range_end_out;
  } out_t;

  function automatic logic usable_type(input logic [TYPE_W-1:0] t);
    return (t == MT_LOADER_CODE) || (t == MT_LOADER_DATA) || (t == MT_BOOT_CODE) ||
           (t == MT_BOOT_DATA) || (t == MT_CONVENTIONAL);
  endfunction

endpackage

/* design/sorted_range_map_insert_core.sv */
// Top level: sorted range table with coalescing inserts, held in one memory.
`timescale 1ns / 1ps

// Channel | Ports                          | Beat
// input   | in_valid, in_ready, in_data    | one add descriptor or read request
// output  | out_valid, out_ready, out_data | one status word per input beat
//
// Steps: a read passes S_RDWAIT, then S_DONE; an add answered at once goes straight to S_DONE.
// An add scans the stored entries and stops at an entry or runs past the last; if it
// inserts below the top, it moves later entries up one per cycle through the range memory.
// Reset: the first state after reset writes entry 0 as an empty range; no beat is taken then.
// Stalls: the output register holds a finished result while the next beat is taken;
// a new result waits in its own register until the output slot frees.

module sorted_range_map_insert_core #(
  parameter int MAX_RANGES = srmi_pkg::MAX_RANGES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  srmi_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output srmi_pkg::out_t  out_data
);

  localparam int AW = srmi_pkg::ADDR_W;
  localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int EW = 2 * AW;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // Range memory: each entry is {start, end}
  logic [EW-1:0] mem [MAX_RANGES];
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic          mem_re;
  logic [IW-1:0] mem_ra;
  logic [EW-1:0] rd_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  logic [2:0]                  state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic                        full_r, full_nxt;
  logic [AW-1:0]               base_r, base_nxt;
  logic [AW-1:0]               end_r, end_nxt;
  logic [CW-1:0]               iss_r, iss_nxt;
  logic                        chk_v_r, chk_v_nxt;
  logic [IW-1:0]               chk_idx_r, chk_idx_nxt;
  logic [AW-1:0]               prev_s_r, prev_s_nxt;
  logic [AW-1:0]               prev_e_r, prev_e_nxt;
  logic [IW-1:0]               pos_r, pos_nxt;
  logic [CW-1:0]               src_r, src_nxt;
  logic                        iss_done_r, iss_done_nxt;
  logic                        mv_v_r, mv_v_nxt;
  logic [IW-1:0]               mv_dst_r, mv_dst_nxt;
  logic [srmi_pkg::STATUS_W-1:0] res_st_r, res_st_nxt;
  logic [AW-1:0]               res_s_r, res_s_nxt;
  logic [AW-1:0]               res_e_r, res_e_nxt;
  logic                        out_valid_r, out_valid_nxt;
  srmi_pkg::out_t              out_r, out_nxt;

  // Descriptor to byte range, saturating at the top of the address space
  logic [AW-1:0] dsc_len;
  logic [AW:0]   dsc_sum;
  logic [AW-1:0] dsc_end;
  logic          dsc_ignore;

  always_comb begin
    dsc_len = (AW'(in_data.page_count) > srmi_pkg::PAGE_LIM) ? srmi_pkg::ADDR_MASK
                                                             : (AW'(in_data.page_count)
                                                                << srmi_pkg::PAGE_SHIFT);
    dsc_sum = {1'b0, in_data.phys_base} + {1'b0, dsc_len};
    dsc_end = dsc_sum[AW] ? srmi_pkg::ADDR_MASK : dsc_sum[AW-1:0];
    dsc_ignore = !srmi_pkg::usable_type(in_data.mem_type) ||
                 (in_data.page_count == '0) || (dsc_end <= in_data.phys_base);
  end

  // Fields of the entry returned by the memory
  logic [AW-1:0] ent_s, ent_e;
  assign ent_s = rd_q[EW-1:AW];
  assign ent_e = rd_q[AW-1:0];

  assign in_ready = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    full_nxt     = full_r;
    base_nxt     = base_r;
    end_nxt      = end_r;
    iss_nxt      = iss_r;
    chk_v_nxt    = chk_v_r;
    chk_idx_nxt  = chk_idx_r;
    prev_s_nxt   = prev_s_r;
    prev_e_nxt   = prev_e_r;
    pos_nxt      = pos_r;
    src_nxt      = src_r;
    iss_done_nxt = iss_done_r;
    mv_v_nxt     = mv_v_r;
    mv_dst_nxt   = mv_dst_r;
    res_st_nxt   = res_st_r;
    res_s_nxt    = res_s_r;
    res_e_nxt    = res_e_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt      = out_r;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = '0;
    mem_re       = 1'b0;
    mem_ra       = '0;

    unique case (state_r)
      S_INIT: begin
        // entry 0 starts as an empty range at address zero
        mem_we    = 1'b1;
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          res_s_nxt = '0;
          res_e_nxt = '0;
          if (in_data.operation == srmi_pkg::OP_READ) begin
            if (32'(in_data.read_index) < 32'(count_r)) begin
              mem_re    = 1'b1;
              mem_ra    = IW'(in_data.read_index);
              state_nxt = S_RDWAIT;
            end else begin
              res_st_nxt = srmi_pkg::ST_READ_BAD;
              state_nxt  = S_DONE;
            end
          end else if (full_r) begin
            res_st_nxt = srmi_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else if (dsc_ignore) begin
            res_st_nxt = srmi_pkg::ST_IGNORED;
            state_nxt  = S_DONE;
          end else begin
            base_nxt  = in_data.phys_base;
            end_nxt   = dsc_end;
            iss_nxt   = '0;
            chk_v_nxt = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_RDWAIT: begin
        res_st_nxt = srmi_pkg::ST_READ_OK;
        res_s_nxt  = ent_s;
        res_e_nxt  = ent_e;
        state_nxt  = S_DONE;
      end

      S_SCAN: begin
        // stream reads one entry per cycle; check the entry read last cycle
        if (iss_r < count_r) begin
          mem_re      = 1'b1;
          mem_ra      = iss_r[IW-1:0];
          iss_nxt     = iss_r + 1'b1;
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = iss_r[IW-1:0];
        end else begin
          chk_v_nxt = 1'b0;
        end

        if (chk_v_r) begin
          if (base_r < ent_e) begin
            if (end_r > ent_s) begin
              res_st_nxt = srmi_pkg::ST_OVERLAP;
              state_nxt  = S_DONE;
            end else if (end_r == ent_s) begin
              // touches the entry above: lower its start
              mem_we     = 1'b1;
              mem_wa     = chk_idx_r;
              mem_wd     = {base_r, ent_e};
              res_st_nxt = srmi_pkg::ST_PREPEND;
              state_nxt  = S_DONE;
            end else if ((chk_idx_r != '0) && (base_r == prev_e_r)) begin
              // touches the entry below: raise its end
              mem_we     = 1'b1;
              mem_wa     = chk_idx_r - 1'b1;
              mem_wd     = {prev_s_r, end_r};
              res_st_nxt = srmi_pkg::ST_APPEND;
              state_nxt  = S_DONE;
            end else if (count_r == MAX_CNT) begin
              full_nxt   = 1'b1;
              res_st_nxt = srmi_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              pos_nxt      = chk_idx_r;
              src_nxt      = count_r - 1'b1;
              iss_done_nxt = 1'b0;
              mv_v_nxt     = 1'b0;
              state_nxt    = S_SHIFT;
            end
          end else begin
            prev_s_nxt = ent_s;
            prev_e_nxt = ent_e;
          end
        end else if (iss_r >= count_r) begin
          // ran past the last entry: append to it or add at the end
          if (base_r == prev_e_r) begin
            mem_we     = 1'b1;
            mem_wa     = IW'(count_r - 1'b1);
            mem_wd     = {prev_s_r, end_r};
            res_st_nxt = srmi_pkg::ST_APPEND;
            state_nxt  = S_DONE;
          end else if (count_r == MAX_CNT) begin
            full_nxt   = 1'b1;
            res_st_nxt = srmi_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            mem_we     = 1'b1;
            mem_wa     = count_r[IW-1:0];
            mem_wd     = {base_r, end_r};
            count_nxt  = count_r + 1'b1;
            res_st_nxt = srmi_pkg::ST_INSERT;
            state_nxt  = S_DONE;
          end
        end
      end

      S_SHIFT: begin
        // move entries up from the top down to the insertion point
        if (!iss_done_r) begin
          mem_re       = 1'b1;
          mem_ra       = src_r[IW-1:0];
          mv_v_nxt     = 1'b1;
          mv_dst_nxt   = IW'(src_r + 1'b1);
          iss_done_nxt = (src_r == CW'(pos_r));
          src_nxt      = src_r - 1'b1;
        end else begin
          mv_v_nxt = 1'b0;
        end

        if (mv_v_r) begin
          mem_we = 1'b1;
          mem_wa = mv_dst_r;
          mem_wd = rd_q;
        end else if (iss_done_r) begin
          mem_we     = 1'b1;
          mem_wa     = pos_r;
          mem_wd     = {base_r, end_r};
          count_nxt  = count_r + 1'b1;
          res_st_nxt = srmi_pkg::ST_INSERT;
          state_nxt  = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_nxt.status          = res_st_r;
          out_nxt.range_count     = srmi_pkg::COUNT_OUT_W'(count_r);
          out_nxt.range_start_out = res_s_r;
          out_nxt.range_end_out   = res_e_r;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CW'(1);
      full_r      <= 1'b0;
      chk_v_r     <= 1'b0;
      iss_done_r  <= 1'b0;
      mv_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      full_r      <= full_nxt;
      chk_v_r     <= chk_v_nxt;
      iss_done_r  <= iss_done_nxt;
      mv_v_r      <= mv_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and index registers
  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    end_r     <= end_nxt;
    iss_r     <= iss_nxt;
    chk_idx_r <= chk_idx_nxt;
    prev_s_r  <= prev_s_nxt;
    prev_e_r  <= prev_e_nxt;
    pos_r     <= pos_nxt;
    src_r     <= src_nxt;
    mv_dst_r  <= mv_dst_nxt;
    res_st_r  <= res_st_nxt;
    res_s_r   <= res_s_nxt;
    res_e_r   <= res_e_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the sorted range map insert core.
`timescale 1ns / 1ps

module tb;

  localparam int AW          = srmi_pkg::ADDR_W;
  localparam int PW          = srmi_pkg::PAGES_W;
  localparam int TW          = srmi_pkg::TYPE_W;
  localparam int RW          = srmi_pkg::RIDX_W;
  localparam int NW          = srmi_pkg::COUNT_OUT_W;
  localparam int TABLE_DEPTH = srmi_pkg::MAX_RANGES_DEF;
  localparam int LIVE_TARGET = 1300;   // random beats staged
  localparam int LATE_FROM   = 1150;   // after this the table may fill up
  localparam int SOFT_CAP    = 26;     // entry limit for inserts before the late part
  localparam int PHASE_LEN   = 160;
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_AT    = 700;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;

  // Idle phases, chosen by the number of beats sent
  localparam int PH_QUIET    = 0;
  localparam int PH_TX_IDLE  = 1;
  localparam int PH_RX_STALL = 2;
  localparam int PH_BOTH     = 3;

  typedef struct packed {
    logic                         full;
    logic [NW-1:0]                cnt;
    logic [TABLE_DEPTH-1:0][AW-1:0] lo;
    logic [TABLE_DEPTH-1:0][AW-1:0] hi;
  } range_map_t;

  typedef struct packed {
    srmi_pkg::in_t  beat;
    srmi_pkg::out_t want;
  } staged_t;

  logic           clk;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  srmi_pkg::in_t  in_data   = '0;
  logic           out_ready = 1'b0;
  logic           in_ready;
  logic           out_valid;
  srmi_pkg::out_t out_data;

  range_map_t     gen_map;
  staged_t        staged_q[$];
  srmi_pkg::out_t result_due_q[$];
  staged_t        on_wire;
  logic           in_took   = 1'b0;
  int             sent_cnt  = 0;
  int             fails     = 0;
  int             quiet     = 0;
  int             hold_left = 0;
  bit             hold_done = 1'b0;

  sorted_range_map_insert_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Firmware types that the table keeps
  function automatic bit kept_type(input logic [TW-1:0] t);
    case (t)
      srmi_pkg::MT_LOADER_CODE, srmi_pkg::MT_LOADER_DATA, srmi_pkg::MT_BOOT_CODE,
      srmi_pkg::MT_BOOT_DATA, srmi_pkg::MT_CONVENTIONAL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Apply one beat to a range table and return the result it answers
  function automatic srmi_pkg::out_t apply_to_map(inout range_map_t m,
                                                  input srmi_pkg::in_t b);
    logic [63:0]    base;
    logic [63:0]    fin;
    logic [63:0]    top;
    int             pos;
    bit             hit;
    bit             clash;
    srmi_pkg::out_t r;
    r = '0;
    hit = 1'b0;
    clash = 1'b0;
    top = {{(64-AW){1'b0}}, srmi_pkg::ADDR_MASK};
    if (b.operation == srmi_pkg::OP_READ) begin
      if (b.read_index < m.cnt) begin
        r.status = srmi_pkg::ST_READ_OK;
        r.range_start_out = m.lo[b.read_index];
        r.range_end_out = m.hi[b.read_index];
      end else begin
        r.status = srmi_pkg::ST_READ_BAD;
      end
    end else if (m.full) begin
      r.status = srmi_pkg::ST_FULL;
    end else if (!kept_type(b.mem_type) || b.page_count == '0) begin
      r.status = srmi_pkg::ST_IGNORED;
    end else begin
      base = {{(64-AW){1'b0}}, b.phys_base};
      fin = base + ({{(64-PW){1'b0}}, b.page_count} << srmi_pkg::PAGE_SHIFT);
      // end saturates at the top of the address space
      if (fin > top) fin = top;
      if (fin <= base) begin
        r.status = srmi_pkg::ST_IGNORED;
      end else begin
        // first entry whose end lies above the base
        pos = int'(m.cnt);
        for (int i = 0; i < int'(m.cnt); i++) begin
          if (!hit && base < {{(64-AW){1'b0}}, m.hi[i]}) begin
            hit = 1'b1;
            if (fin <= {{(64-AW){1'b0}}, m.lo[i]}) pos = i;
            else clash = 1'b1;
          end
        end
        if (clash) begin
          r.status = srmi_pkg::ST_OVERLAP;
        end else if (pos < int'(m.cnt) && fin == {{(64-AW){1'b0}}, m.lo[pos]}) begin
          m.lo[pos] = base[AW-1:0];
          r.status = srmi_pkg::ST_PREPEND;
        end else if (pos > 0 && base == {{(64-AW){1'b0}}, m.hi[pos-1]}) begin
          m.hi[pos-1] = fin[AW-1:0];
          r.status = srmi_pkg::ST_APPEND;
        end else if (int'(m.cnt) >= TABLE_DEPTH) begin
          m.full = 1'b1;
          r.status = srmi_pkg::ST_FULL;
        end else begin
          for (int i = int'(m.cnt); i > pos; i--) begin
            m.lo[i] = m.lo[i-1];
            m.hi[i] = m.hi[i-1];
          end
          m.lo[pos] = base[AW-1:0];
          m.hi[pos] = fin[AW-1:0];
          m.cnt = m.cnt + 1'b1;
          r.status = srmi_pkg::ST_INSERT;
        end
      end
    end
    r.range_count = m.cnt;
    return r;
  endfunction

  // Queue a beat with its result; an insert past the cap is refused (-1)
  function automatic int stage_beat(input srmi_pkg::in_t b, input int cap);
    range_map_t     trial;
    srmi_pkg::out_t r;
    int             cnt_now;
    trial = gen_map;
    r = apply_to_map(trial, b);
    cnt_now = int'(gen_map.cnt);
    if (r.status == srmi_pkg::ST_INSERT && cnt_now >= cap) return -1;
    gen_map = trial;
    staged_q.push_back({b, r});
    return int'(r.status);
  endfunction

  function automatic srmi_pkg::in_t add_beat(input logic [TW-1:0] t,
                                             input logic [AW-1:0] base,
                                             input logic [PW-1:0] pages);
    srmi_pkg::in_t b;
    b = '0;
    b.operation = srmi_pkg::OP_ADD;
    b.mem_type = t;
    b.phys_base = base;
    b.page_count = pages;
    return b;
  endfunction

  function automatic srmi_pkg::in_t read_beat(input logic [RW-1:0] idx);
    srmi_pkg::in_t b;
    b = '0;
    b.operation = srmi_pkg::OP_READ;
    b.read_index = idx;
    return b;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random beat shaped by the current table: often neighbors of stored ranges
  function automatic srmi_pkg::in_t make_beat(input bit late);
    srmi_pkg::in_t  b;
    int             k;
    int             i;
    int             j;
    logic [AW-1:0]  len;
    logic [AW-1:0]  span;
    logic [63:0]    rnd;
    rnd = rand64();
    b.operation = srmi_pkg::OP_ADD;
    case ($urandom_range(0, 4))
      0: b.mem_type = srmi_pkg::MT_LOADER_CODE;
      1: b.mem_type = srmi_pkg::MT_LOADER_DATA;
      2: b.mem_type = srmi_pkg::MT_BOOT_CODE;
      3: b.mem_type = srmi_pkg::MT_BOOT_DATA;
      default: b.mem_type = srmi_pkg::MT_CONVENTIONAL;
    endcase
    if ($urandom_range(0, 9) == 0) b.mem_type = TW'($urandom_range(0, 15));
    b.phys_base = rnd[AW-1:0];
    b.page_count = PW'($urandom_range(1, 8));
    b.read_index = RW'($urandom_range(0, 31));
    k = $urandom_range(0, 99);
    if (late && k < 50) k = 75;
    i = $urandom_range(0, int'(gen_map.cnt) - 1);
    j = (gen_map.cnt > 1) ? $urandom_range(1, int'(gen_map.cnt) - 1) : 0;
    if (k < 15) begin
      b.operation = srmi_pkg::OP_READ;
      if ($urandom_range(0, 9) < 7) b.read_index = RW'(i);
    end else if (k < 35) begin
      // touch the end of a stored range
      b.phys_base = gen_map.hi[i];
    end else if (k < 55) begin
      // end right at the start of a stored range
      len = AW'(b.page_count) << srmi_pkg::PAGE_SHIFT;
      b.phys_base = gen_map.lo[j] - len;
    end else if (k < 70) begin
      span = gen_map.hi[i] - gen_map.lo[i];
      if (span != '0) b.phys_base = gen_map.lo[i] + AW'(rnd % {{(64-AW){1'b0}}, span});
      else b.phys_base = gen_map.lo[i];
    end else if (k < 85) begin
      b.page_count = PW'($urandom_range(1, 64));
    end else begin
      // noise: any type, any size, zero pages now and then
      rnd = rand64();
      b.mem_type = TW'($urandom_range(0, 15));
      b.page_count = rnd[PW-1:0] >> $urandom_range(0, PW - 1);
      if ($urandom_range(0, 3) == 0) b.page_count = '0;
    end
    return b;
  endfunction

  function automatic int idle_pct(input bit rx_side);
    int ph;
    ph = (sent_cnt / PHASE_LEN) % 4;
    if (ph == PH_QUIET) return 0;
    if (ph == PH_BOTH) return 27;
    if (ph == PH_TX_IDLE && !rx_side) return 59;
    if (ph == PH_RX_STALL && rx_side) return 59;
    return 0;
  endfunction

  task automatic check_field(input string name, input logic [AW-1:0] want,
                             input logic [AW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  // Sender: next beat once the current one is taken
  always @(negedge clk) begin : drive
    bit gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      gap = ($urandom_range(0, 99) < idle_pct(1'b0));
      // one pause until every outstanding result is back
      if (sent_cnt == DRAIN_AT && result_due_q.size() != 0) gap = 1'b1;
      if (staged_q.size() != 0 && !gap) begin
        on_wire = staged_q.pop_front();
        in_data <= on_wire.beat;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && sent_cnt >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // Scoreboard and watchdog
  always @(posedge clk) begin : score
    srmi_pkg::out_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        result_due_q.push_back(on_wire.want);
        sent_cnt <= sent_cnt + 1;
      end
      if (out_valid && out_ready) begin
        if (result_due_q.size() == 0) begin
          $error("result beat with nothing outstanding: status %0d", out_data.status);
          fails++;
        end else begin
          want = result_due_q.pop_front();
          check_field("status", AW'(want.status), AW'(out_data.status));
          check_field("range_count", AW'(want.range_count), AW'(out_data.range_count));
          check_field("range_start_out", want.range_start_out, out_data.range_start_out);
          check_field("range_end_out", want.range_end_out, out_data.range_end_out);
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet = quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("sorted_range_map_insert_core regression: fail");
      $finish;
    end
  end

  initial begin
    int            live;
    int            st;
    int            total;
    srmi_pkg::in_t b;
    gen_map = '0;
    gen_map.cnt = NW'(1);

    // Directed: empty entry zero, each status but full, address extremes
    st = stage_beat(read_beat(5'd0), TABLE_DEPTH + 1);
    st = stage_beat(read_beat(5'd31), TABLE_DEPTH + 1);
    // grows entry zero
    st = stage_beat(add_beat(srmi_pkg::MT_CONVENTIONAL, '0, 36'd1), TABLE_DEPTH + 1);
    st = stage_beat(add_beat(4'd0, 48'h10000, 36'd1), TABLE_DEPTH + 1);
    st = stage_beat(add_beat(srmi_pkg::MT_LOADER_CODE, 48'h20000, '0), TABLE_DEPTH + 1);
    st = stage_beat(add_beat(srmi_pkg::MT_LOADER_DATA, 48'h10000, 36'd2), TABLE_DEPTH + 1);
    st = stage_beat(add_beat(srmi_pkg::MT_BOOT_CODE, 48'hE000, 36'd2), TABLE_DEPTH + 1);
    st = stage_beat(add_beat(srmi_pkg::MT_BOOT_DATA, 48'h12000, 36'd1), TABLE_DEPTH + 1);
    st = stage_beat(add_beat(srmi_pkg::MT_CONVENTIONAL, 48'h11000, 36'd1), TABLE_DEPTH + 1);
    st = stage_beat(add_beat(srmi_pkg::MT_LOADER_CODE, '0, 36'd1), TABLE_DEPTH + 1);
    // empty after clipping at the top of the address space
    st = stage_beat(add_beat(srmi_pkg::MT_CONVENTIONAL, srmi_pkg::ADDR_MASK, 36'd1),
                    TABLE_DEPTH + 1);
    st = stage_beat(add_beat(srmi_pkg::MT_CONVENTIONAL, 48'hFFFF_FFFF_0000, '1),
                    TABLE_DEPTH + 1);
    st = stage_beat(add_beat(srmi_pkg::MT_LOADER_DATA, 48'h2000_0000, '1), TABLE_DEPTH + 1);
    st = stage_beat(add_beat(4'hF, srmi_pkg::ADDR_MASK, '1), TABLE_DEPTH + 1);
    st = stage_beat(read_beat(5'd1), TABLE_DEPTH + 1);
    st = stage_beat(read_beat(5'd2), TABLE_DEPTH + 1);
    st = stage_beat(read_beat(5'd3), TABLE_DEPTH + 1);
    // shifts entries up
    st = stage_beat(add_beat(srmi_pkg::MT_BOOT_DATA, 48'h3000, 36'd1), TABLE_DEPTH + 1);
    st = stage_beat(read_beat(5'd2), TABLE_DEPTH + 1);
    // touches both neighbors; prepend wins
    st = stage_beat(add_beat(srmi_pkg::MT_BOOT_CODE, 48'h1000, 36'd2), TABLE_DEPTH + 1);
    st = stage_beat(read_beat(5'd1), TABLE_DEPTH + 1);

    // Random: hold inserts back until late so the sticky full state comes last
    live = 0;
    while (live < LIVE_TARGET) begin
      b = make_beat(live >= LATE_FROM);
      st = stage_beat(b, (live >= LATE_FROM) ? TABLE_DEPTH + 1 : SOFT_CAP);
      if (st >= 0) live++;
    end
    total = staged_q.size();

    while (sent_cnt != total || result_due_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fails == 0) $display("sorted_range_map_insert_core regression: pass");
    else $display("sorted_range_map_insert_core regression: fail");
    $finish;
  end

endmodule
